### rtl/core/assert_macros.svh
// assertion macros shared by the flanger rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define SFL_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SFL_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SFL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sfl_pkg.sv
// shared types, constants and arithmetic helpers of the stereo flanger
`default_nettype none
package sfl_pkg;

   localparam int SAMPLE_W = 24;
   localparam int IP_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] REG_LFO_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_DEPTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_DELAY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WET_MIX       = 3'd4;

   localparam logic [16:0] GAIN_ONE = 17'd65536;
   localparam logic signed [15:0] FB_LIMIT = 16'sd31129;
   localparam longint Q30 = 64'sd1 << 30;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [IP_W-1:0]            ip;
      logic [7:0]                 frac;
   } sfl_item_type;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input longint v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 64'sd8388607) r = 24'sd8388607;
      else if (v < -64'sd8388608) r = -24'sd8388608;
      else r = v[SAMPLE_W-1:0];
      return r;
   endfunction

   // arithmetic shift that rounds toward zero
   function automatic longint shr_tz(input longint v, input int n);
      longint b;
      b = (v < 0) ? v + ((64'sd1 <<< n) - 64'sd1) : v;
      return b >>> n;
   endfunction

   // quarter-wave sine magnitude in q1.16, u is the angle fraction in q0.30
   function automatic logic [16:0] rom_mag(input longint u);
      longint u2, p, s, mag;
      u2 = u * u / Q30;
      p = 64'sd172271;
      p = -64'sd5026994 + p * u2 / Q30;
      p = 64'sd85569306 + p * u2 / Q30;
      p = -64'sd693598690 + p * u2 / Q30;
      p = 64'sd1686629713 + p * u2 / Q30;
      s = p * u / Q30;
      if (s < 0) s = 0;
      mag = (s + 64'sd8192) / 64'sd16384;
      if (mag > 64'sd65536) mag = 64'sd65536;
      return mag[16:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/sfl_front.sv
// front end: takes a sample pair, runs the lfo and works out the tap delay
`default_nettype none
module sfl_front #(
   parameter int BUFFER_DEPTH     = 4096,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [47:0]          req_tdata,  // left_in[23:0], right_in[47:24]
   input  wire logic [22:0]          lfo_step,
   input  wire logic [16:0]          lfo_depth,
   input  wire logic [19:0]          base_delay,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output sfl_pkg::sfl_item_type     push_item
);
   import sfl_pkg::*;

   localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int IW = $clog2(SINE_TABLE_DEPTH);
   localparam int PW = 22 + KW;
   localparam int DW = $clog2(BUFFER_DEPTH) + 8;
   localparam logic signed [24:0] DLY_LO = 25'sd256;
   localparam logic signed [24:0] DLY_HI = 25'((BUFFER_DEPTH - 2) * 256);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_ROM  = 3'd1;
   localparam logic [2:0] F_DEP  = 3'd2;
   localparam logic [2:0] F_HI   = 3'd3;
   localparam logic [2:0] F_LO   = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [23:0] phase_ff, phase_in;
   logic [KW-1:0] k_ff;
   logic        neg_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic [16:0] mag_ff;
   logic [32:0] mod_ff;
   logic [36:0] phi_ff;
   logic [53:0] sum_ff;

   logic [16:0] rom_w [SINE_TABLE_DEPTH+1];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam longint U = (longint'(g) << 30) / SINE_TABLE_DEPTH;
      assign rom_w[g] = rom_mag(U);
   end

   logic [PW-1:0] pos_scaled;
   logic [IW-1:0] idx;
   logic [KW-1:0] k_c;
   logic [22:0]   step_c;
   logic [16:0]   depth_c;
   logic          accept;
   logic [21:0]   q_c;
   logic signed [24:0] dsum, dclamp;
   logic [DW-1:0] dly;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == F_IDLE);
   assign pos_scaled = PW'(phase_ff[21:0]) * PW'(SINE_TABLE_DEPTH);
   assign idx        = pos_scaled[22 +: IW];
   assign k_c        = phase_ff[22] ? KW'(SINE_TABLE_DEPTH) - KW'(idx) : KW'(idx);
   assign step_c     = (lfo_step == 23'd0) ? 23'd1 : lfo_step;
   assign depth_c    = (lfo_depth > GAIN_ONE) ? GAIN_ONE : lfo_depth;

   assign q_c  = sum_ff[53:32];
   assign dsum = neg_ff ? 25'(base_delay) - 25'(q_c) : 25'(base_delay) + 25'(q_c);

   always_comb begin
      priority if (dsum < DLY_LO) dclamp = DLY_LO;
      else if (dsum > DLY_HI) dclamp = DLY_HI;
      else dclamp = dsum;
   end

   assign dly = dclamp[DW-1:0];
   assign push_valid      = (state_ff == F_PUSH);
   assign push_item.left  = left_ff;
   assign push_item.right = right_ff;
   assign push_item.ip    = IP_W'(dly[DW-1:8]);
   assign push_item.frac  = dly[7:0];

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_ROM;
               phase_in = phase_ff + 24'(step_c);
            end
         end
         F_ROM:  state_in = F_DEP;
         F_DEP:  state_in = F_HI;
         F_HI:   state_in = F_LO;
         F_LO:   state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= 24'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         k_ff     <= k_c;
         neg_ff   <= phase_ff[23];
         left_ff  <= req_tdata[23:0];
         right_ff <= req_tdata[47:24];
      end
      if (state_ff == F_ROM) mag_ff <= rom_w[k_ff];
      if (state_ff == F_DEP) mod_ff <= 33'(depth_c * mag_ff);
      // base times modulation, split into two partial products
      if (state_ff == F_HI) phi_ff <= 37'(base_delay * mod_ff[32:16]);
      if (state_ff == F_LO) sum_ff <= {1'b0, phi_ff, 16'd0} + 54'(base_delay * mod_ff[15:0]);
   end

endmodule
`default_nettype wire

### rtl/core/sfl_queue.sv
// two-entry queue between the front end and the delay-line engine
`default_nettype none
module sfl_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sfl_pkg::sfl_item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sfl_pkg::sfl_item_type   out_item
);
   import sfl_pkg::*;

   `include "assert_macros.svh"

   sfl_item_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_item;
   end

   `SFL_ASSERT_ALWAYS(a_count_bound, count_ff <= 2'd2, "queue count beyond depth")
   `SFL_ASSERT_IMPL(a_ptr_match, count_ff == 2'd0 || count_ff == 2'd2,
      wr_ptr_ff == rd_ptr_ff, "queue pointers out of step with count")

endmodule
`default_nettype wire

### rtl/core/sfl_back.sv
// delay-line engine: feedback write, two-tap interpolation, dry/wet mix
`default_nettype none
module sfl_back #(
   parameter int BUFFER_DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire sfl_pkg::sfl_item_type pop_item,
   input  wire logic signed [15:0]    feedback_gain,
   input  wire logic [16:0]           wet_mix,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata   // left_out[23:0], right_out[47:24]
);
   import sfl_pkg::*;

   `include "assert_macros.svh"

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_RD1  = 3'd1;
   localparam logic [2:0] B_INT  = 3'd2;
   localparam logic [2:0] B_MIX  = 3'd3;
   localparam logic [2:0] B_OUT  = 3'd4;

   logic signed [SAMPLE_W-1:0] left_mem  [BUFFER_DEPTH];
   logic signed [SAMPLE_W-1:0] right_mem [BUFFER_DEPTH];

   logic [2:0]    state_ff;
   logic [AW-1:0] wp_ff;
   logic          wrapped_ff;
   logic signed [SAMPLE_W-1:0] last_l_ff, last_r_ff;
   logic          rsp_tvalid_ff;
   logic signed [SAMPLE_W-1:0] out_l_ff, out_r_ff;

   sfl_item_type  it_ff;
   logic [AW-1:0] i1_ff;
   logic          ok0_ff, ok1_ff;
   logic signed [SAMPLE_W-1:0] rd_l_ff, rd_r_ff, a_l_ff, a_r_ff;
   logic signed [41:0] px_l_ff, px_r_ff;
   logic signed [34:0] acc_l_ff, acc_r_ff;
   logic signed [42:0] mix_l_ff, mix_r_ff;

   logic          pop;
   logic signed [15:0] fb_c;
   logic [16:0]   mix_c;
   logic [AW-1:0] ip_c, i0_c, i1_c, raddr;
   logic signed [SAMPLE_W-1:0] wl_c, wr_c, b_l_c, b_r_c, dl_c, dr_c;
   logic signed [9:0] wa_c, wb_c;
   logic signed [17:0] dry_g, wet_g;
   logic          out_free;

   assign pop       = pop_valid && pop_ready;
   assign pop_ready = (state_ff == B_IDLE);
   assign out_free  = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      priority if (feedback_gain > FB_LIMIT) fb_c = FB_LIMIT;
      else if (feedback_gain < -FB_LIMIT) fb_c = -FB_LIMIT;
      else fb_c = feedback_gain;
   end

   assign mix_c = (wet_mix > GAIN_ONE) ? GAIN_ONE : wet_mix;
   assign dry_g = 18'(GAIN_ONE - mix_c);
   assign wet_g = 18'(mix_c);

   // input plus scaled feedback of the last delayed sample
   assign wl_c = sat24(longint'(pop_item.left)
                       + shr_tz(longint'(fb_c * 40'(last_l_ff)), 15));
   assign wr_c = sat24(longint'(pop_item.right)
                       + shr_tz(longint'(fb_c * 40'(last_r_ff)), 15));

   // tap addresses modulo the line length
   assign ip_c = pop_item.ip[AW-1:0];
   assign i0_c = (wp_ff >= ip_c) ? wp_ff - ip_c
                 : AW'((AW+1)'(wp_ff) + (AW+1)'(BUFFER_DEPTH) - (AW+1)'(ip_c));
   assign i1_c = (i0_c == '0) ? LAST_ADDR : i0_c - 1'b1;
   assign raddr = (state_ff == B_IDLE) ? i0_c : i1_ff;

   assign wa_c  = 10'(9'd256 - 9'(it_ff.frac));
   assign wb_c  = 10'(it_ff.frac);
   assign b_l_c = ok1_ff ? rd_l_ff : '0;
   assign b_r_c = ok1_ff ? rd_r_ff : '0;
   assign dl_c  = sat24(shr_tz(longint'(acc_l_ff), 8));
   assign dr_c  = sat24(shr_tz(longint'(acc_r_ff), 8));

   always_ff @(posedge clock) begin
      if (pop) begin
         left_mem[wp_ff]  <= wl_c;
         right_mem[wp_ff] <= wr_c;
      end
      rd_l_ff <= left_mem[raddr];
      rd_r_ff <= right_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         last_l_ff     <= '0;
         last_r_ff     <= '0;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  state_ff <= B_RD1;
                  if (wp_ff == LAST_ADDR) begin
                     wp_ff      <= '0;
                     wrapped_ff <= 1'b1;
                  end else begin
                     wp_ff <= wp_ff + 1'b1;
                  end
               end
            end
            B_RD1: state_ff <= B_INT;
            B_INT: state_ff <= B_MIX;
            B_MIX: begin
               state_ff  <= B_OUT;
               last_l_ff <= dl_c;
               last_r_ff <= dr_c;
            end
            B_OUT: begin
               if (out_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // result beat is raised by the output step and held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == B_OUT && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         it_ff  <= pop_item;
         i1_ff  <= i1_c;
         // entries not yet written since reset read as zero
         ok0_ff <= wrapped_ff || (i0_c < wp_ff);
         ok1_ff <= wrapped_ff || (i1_c < wp_ff);
      end
      if (state_ff == B_RD1) begin
         a_l_ff  <= ok0_ff ? rd_l_ff : '0;
         a_r_ff  <= ok0_ff ? rd_r_ff : '0;
         px_l_ff <= 42'(it_ff.left * dry_g);
         px_r_ff <= 42'(it_ff.right * dry_g);
      end
      if (state_ff == B_INT) begin
         acc_l_ff <= 35'(a_l_ff * wa_c) + 35'(b_l_c * wb_c);
         acc_r_ff <= 35'(a_r_ff * wa_c) + 35'(b_r_c * wb_c);
      end
      if (state_ff == B_MIX) begin
         mix_l_ff <= 43'(px_l_ff) + 43'(dl_c * wet_g);
         mix_r_ff <= 43'(px_r_ff) + 43'(dr_c * wet_g);
      end
      if (state_ff == B_OUT && out_free) begin
         out_l_ff <= sat24(shr_tz(longint'(mix_l_ff), 16));
         out_r_ff <= sat24(shr_tz(longint'(mix_r_ff), 16));
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {out_r_ff, out_l_ff};

   `SFL_ASSERT_NEXT(a_pop_starts, pop, state_ff == B_RD1, "pop did not start the engine")
   `SFL_ASSERT_IMPL(a_rsp_source, $rose(rsp_tvalid_ff), $past(state_ff) == B_OUT,
      "result raised outside the output step")
   `SFL_ASSERT_NEXT(a_wp_moves, pop && !$past(reset), wp_ff != $past(wp_ff),
      "write position did not advance")

endmodule
`default_nettype wire

### rtl/core/stereo_flanger_top.sv
// stereo flanger top level: control registers, front end, queue and engine
// each pair runs through the front sequencer, the queue and the engine to a result beat
// front takes a new pair only after pushing the last; the engine pops only when idle
// the engine uses 5 steps since each delay-line memory has one read port for two taps
// reset: synchronous; registers take their defaults, lfo phase and write position clear,
// delay lines read as zero until written (fill tracking, no clearing pass)
`default_nettype none
module stereo_flanger_top #(
   parameter int BUFFER_DEPTH     = 4096,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // left_in[23:0], right_in[47:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // left_out[23:0], right_out[47:24]
   input  wire logic        csr_wr_en,
   input  wire logic [sfl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sfl_pkg::*;

   logic [22:0] lfo_step_ff;
   logic [16:0] lfo_depth_ff;
   logic signed [15:0] feedback_gain_ff;
   logic [19:0] base_delay_ff;
   logic [16:0] wet_mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_step_ff      <= 23'd87;
         lfo_depth_ff     <= 17'd32768;
         feedback_gain_ff <= 16'sd0;
         base_delay_ff    <= 20'd24576;
         wet_mix_ff       <= 17'd32768;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_LFO_STEP:      lfo_step_ff      <= csr_wdata[22:0];
            REG_LFO_DEPTH:     lfo_depth_ff     <= csr_wdata[16:0];
            REG_FEEDBACK_GAIN: feedback_gain_ff <= csr_wdata[15:0];
            REG_BASE_DELAY:    base_delay_ff    <= csr_wdata[19:0];
            REG_WET_MIX:       wet_mix_ff       <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   logic         push_valid, push_ready, pop_valid, pop_ready;
   sfl_item_type push_item, pop_item;

   sfl_front #(
      .BUFFER_DEPTH     (BUFFER_DEPTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .lfo_step   (lfo_step_ff),
      .lfo_depth  (lfo_depth_ff),
      .base_delay (base_delay_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sfl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item)
   );

   sfl_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .feedback_gain (feedback_gain_ff),
      .wet_mix       (wet_mix_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule
`default_nettype wire
